/* src/fia_pkg.sv */
// ----------------------------------------------------------------------------
// fia_pkg
// Shared types and constants for the flow ID allocator: request and status
// codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package fia_pkg;

  localparam int unsigned ID_BITS   = 12;
  localparam int unsigned MODE_BITS = 2;
  localparam int unsigned STAT_BITS = 2;
  localparam int unsigned MAP_DEPTH = 1 << ID_BITS;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_FREE    = 2'd1,
    MODE_RESERVE = 2'd2
  } mode_e;

  typedef enum logic [STAT_BITS-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_POP,
    S_CHK
  } state_e;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic exec_simple;
    logic pop_rd;
    logic pop_done;
    logic adv;
    logic chk_done;
    logic exhausted;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_alloc;
    logic fifo_nonempty;
    logic can_adv;
    logic rsv_hit;
  } dp_stat_t;

endpackage

`default_nettype wire

/* src/fia_ram.sv */
// ----------------------------------------------------------------------------
// fia_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fia_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/fia_ctrl.sv */
// ----------------------------------------------------------------------------
// fia_ctrl
// Controller: sequences the reserved-map clearing pass, request decode,
// free-list pop and the counter advance over reserved IDs.
// ----------------------------------------------------------------------------
`default_nettype none

module fia_ctrl
  import fia_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output      logic      busy,
  input  wire dp_stat_t  stat_i,
  output      ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (!stat_i.is_alloc) begin
          state_d = S_IDLE;
        end else if (stat_i.fifo_nonempty) begin
          state_d = S_POP;
        end else if (stat_i.can_adv) begin
          state_d = S_CHK;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_POP: begin
        state_d = S_IDLE;
      end
      S_CHK: begin
        if (!stat_i.rsv_hit || !stat_i.can_adv) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = (state_q != S_IDLE);
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
      end
      S_IDLE: begin
        cmd_o.load = start;
      end
      S_EXEC: begin
        priority if (!stat_i.is_alloc) begin
          cmd_o.exec_simple = 1'b1;
        end else if (stat_i.fifo_nonempty) begin
          cmd_o.pop_rd = 1'b1;
        end else if (stat_i.can_adv) begin
          cmd_o.adv = 1'b1;
        end else begin
          cmd_o.exhausted = 1'b1;
        end
      end
      S_POP: begin
        cmd_o.pop_done = 1'b1;
      end
      S_CHK: begin
        priority if (!stat_i.rsv_hit) begin
          cmd_o.chk_done = 1'b1;
        end else if (stat_i.can_adv) begin
          cmd_o.adv = 1'b1;
        end else begin
          cmd_o.exhausted = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

/* src/fia_dp.sv */
// ----------------------------------------------------------------------------
// fia_dp
// Datapath: request registers, high-water counter, free-list FIFO with its
// pointers and count, reserved-ID map, clearing counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fia_dp
  import fia_pkg::*;
#(
  parameter int unsigned ID_LIMIT   = 4094,
  parameter int unsigned FREE_DEPTH = 4096
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ctrl_cmd_t            cmd_i,
  output      dp_stat_t             stat_o,
  input  wire logic                 unique_mode_i,
  input  wire logic [MODE_BITS-1:0] mode_i,
  input  wire logic [ID_BITS-1:0]   id_in_i,
  output      logic [ID_BITS-1:0]   id_out_o,
  output      logic [STAT_BITS-1:0] status_o,
  output      logic                 done_o
);

  localparam int unsigned PW = $clog2(FREE_DEPTH);
  localparam int unsigned CW = $clog2(FREE_DEPTH + 1);
  localparam logic [ID_BITS:0] LIMIT = (ID_BITS + 1)'(ID_LIMIT);
  localparam logic [PW-1:0]    LAST_PTR = PW'(FREE_DEPTH - 1);
  localparam logic [CW-1:0]    FULL_CNT = CW'(FREE_DEPTH);

  logic [MODE_BITS-1:0] mode_q;
  logic [ID_BITS-1:0]   id_q;
  logic [ID_BITS-1:0]   hw_q, hw_d;
  logic [PW-1:0]        head_q, head_d;
  logic [PW-1:0]        tail_q, tail_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [ID_BITS-1:0]   clr_q, clr_d;
  logic                 done_q, done_d;
  logic [ID_BITS-1:0]   id_out_q, id_out_d;
  logic [STAT_BITS-1:0] status_q, status_d;

  logic [ID_BITS-1:0]   hw_inc;
  logic                 fifo_we;
  logic [ID_BITS-1:0]   fifo_rdata;
  logic                 map_we;
  logic [ID_BITS-1:0]   map_waddr;
  logic                 map_rdata;
  logic                 do_free;

  assign hw_inc  = hw_q + ID_BITS'(1);
  assign do_free = (mode_q == MODE_FREE) && !unique_mode_i;

  assign stat_o.clr_last      = (clr_q == '1);
  assign stat_o.is_alloc      = (mode_q == MODE_ALLOC);
  assign stat_o.fifo_nonempty = (cnt_q != '0);
  assign stat_o.can_adv       = (({1'b0, hw_q} + (ID_BITS + 1)'(1)) < LIMIT);
  assign stat_o.rsv_hit       = map_rdata;

  assign fifo_we = cmd_i.exec_simple && do_free && (id_q != hw_q) && (cnt_q != FULL_CNT);
  assign map_we  = cmd_i.clr_step || (cmd_i.exec_simple && (mode_q == MODE_RESERVE));
  assign map_waddr = cmd_i.clr_step ? clr_q : id_q;

  always_comb begin
    hw_d     = hw_q;
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    clr_d    = clr_q;
    done_d   = 1'b0;
    id_out_d = id_out_q;
    status_d = status_q;

    if (cmd_i.clr_step) clr_d = clr_q + ID_BITS'(1);
    if (cmd_i.adv) hw_d = hw_inc;

    if (cmd_i.exec_simple) begin
      done_d   = 1'b1;
      id_out_d = '0;
      status_d = ST_OK;
      if (do_free) begin
        priority if (id_q == hw_q) begin
          hw_d = hw_q - ID_BITS'(1);
        end else if (cnt_q == FULL_CNT) begin
          status_d = ST_OVERFLOW;
        end else begin
          tail_d = (tail_q == LAST_PTR) ? '0 : tail_q + PW'(1);
          cnt_d  = cnt_q + CW'(1);
        end
      end
    end

    if (cmd_i.pop_done) begin
      done_d   = 1'b1;
      id_out_d = fifo_rdata;
      status_d = ST_OK;
      head_d   = (head_q == LAST_PTR) ? '0 : head_q + PW'(1);
      cnt_d    = cnt_q - CW'(1);
    end

    if (cmd_i.chk_done) begin
      done_d   = 1'b1;
      id_out_d = hw_q;
      status_d = ST_OK;
    end

    if (cmd_i.exhausted) begin
      done_d   = 1'b1;
      id_out_d = '0;
      status_d = ST_EXHAUSTED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q   <= ID_BITS'(1);
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
      clr_q  <= '0;
      done_q <= 1'b0;
    end else begin
      hw_q   <= hw_d;
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
      clr_q  <= clr_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      id_q   <= id_in_i;
    end
    id_out_q <= id_out_d;
    status_q <= status_d;
  end

  fia_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (FREE_DEPTH)
  ) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (tail_q),
    .wdata_i (id_q),
    .raddr_i (head_q),
    .rdata_o (fifo_rdata)
  );

  fia_ram #(
    .WIDTH (1),
    .DEPTH (MAP_DEPTH)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (~cmd_i.clr_step),
    .raddr_i (hw_inc),
    .rdata_o (map_rdata)
  );

  assign id_out_o = id_out_q;
  assign status_o = status_q;
  assign done_o   = done_q;

endmodule

`default_nettype wire

/* src/flow_id_allocator_top.sv */
// ----------------------------------------------------------------------------
// flow_id_allocator_top
// Free, reserve and other requests are registered on accept, executed in S_EXEC
// and strobed from the result registers; a new request is accepted only once the
// controller is back in S_IDLE. Allocate pops the free list through S_POP, else
// advances the counter through S_CHK, skipping reserved IDs (one reserved-map read
// per cycle), or reports exhaustion when the counter is at the limit. After reset,
// busy stays high while the reserved map is cleared one entry per cycle; the receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none

module flow_id_allocator_top
  import fia_pkg::*;
#(
  parameter int unsigned ID_LIMIT   = 4094,
  parameter int unsigned FREE_DEPTH = 4096
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output      logic                 busy,
  input  wire logic [MODE_BITS-1:0] mode_i,
  input  wire logic [ID_BITS-1:0]   id_in_i,
  output      logic [ID_BITS-1:0]   id_out_o,
  output      logic [STAT_BITS-1:0] status_o,
  output      logic                 done_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output      logic [31:0]          prdata,
  output      logic                 pready
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      unique_q, unique_d;
  logic      sel_unique;

  assign pready     = 1'b1;
  assign sel_unique = (paddr[2] == 1'b0);

  always_comb begin
    unique_d = unique_q;
    if (psel && penable && pwrite && sel_unique) unique_d = pwdata[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unique_q <= 1'b0;
    end else begin
      unique_q <= unique_d;
    end
  end

  assign prdata = sel_unique ? {31'd0, unique_q} : 32'd0;

  fia_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  fia_dp #(
    .ID_LIMIT   (ID_LIMIT),
    .FREE_DEPTH (FREE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .unique_mode_i (unique_q),
    .mode_i        (mode_i),
    .id_in_i       (id_in_i),
    .id_out_o      (id_out_o),
    .status_o      (status_o),
    .done_o        (done_o)
  );

endmodule

`default_nettype wire

/* bench/tb_flow_id_allocator_top.sv */
// ----------------------------------------------------------------------------
// tb_flow_id_allocator_top
// Self-checking bench for the flow ID allocator. A driver feeds allocate,
// free, reserve and unused requests from a queue, and a shadow allocator
// predicts each grant. A monitor compares every strobed result with the
// oldest prediction. Phases cover directed corner cases, random traffic in
// both unique-mode settings with varied sender gaps, and counter wrap and
// exhaustion near the limit.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_flow_id_allocator_top;
  import fia_pkg::*;

  localparam int ID_LIMIT        = 4094;
  localparam int FREE_DEPTH      = 4096;
  localparam int REG_UNIQUE_MODE = 0;
  localparam int STALL_LIMIT     = 20000;
  localparam int SETTLE_CYCLES   = 10;
  localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [MODE_BITS-1:0] mode;
    logic [ID_BITS-1:0]   id;
    bit                   hold;
  } flow_req_t;

  typedef struct {
    logic [ID_BITS-1:0] id;
    status_e            st;
  } grant_t;

  logic                 clk_i   = 1'b0;
  logic                 rst_ni  = 1'b0;
  logic                 start   = 1'b0;
  logic                 busy;
  logic [MODE_BITS-1:0] mode_i  = '0;
  logic [ID_BITS-1:0]   id_in_i = '0;
  logic [ID_BITS-1:0]   id_out_o;
  logic [STAT_BITS-1:0] status_o;
  logic                 done_o;
  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [2:0]           paddr   = '0;
  logic [31:0]          pwdata  = '0;
  logic [31:0]          prdata;
  logic                 pready;

  flow_req_t          pending_req_q[$];
  grant_t             expected_grant_q[$];
  int                 gap_pct   = 0;
  int                 err_cnt   = 0;
  int                 stall_cnt = 0;

  bit [ID_BITS-1:0]   hw_cnt = 1;
  bit [ID_BITS-1:0]   freed_ids_q[$];
  bit [ID_BITS-1:0]   granted_ids_q[$];
  bit [MAP_DEPTH-1:0] rsv_map = '0;
  bit                 unique_sh = 1'b0;

  flow_id_allocator_top #(
    .ID_LIMIT  (ID_LIMIT),
    .FREE_DEPTH(FREE_DEPTH)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .mode_i  (mode_i),
    .id_in_i (id_in_i),
    .id_out_o(id_out_o),
    .status_o(status_o),
    .done_o  (done_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit bump_hw();
    if (int'(hw_cnt) + 1 < ID_LIMIT) begin
      hw_cnt = hw_cnt + 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void compute_grant(logic [MODE_BITS-1:0] m, logic [ID_BITS-1:0] id);
    grant_t g;
    bit     ok;
    g.id = '0;
    g.st = ST_OK;
    case (m)
      MODE_ALLOC: begin
        if (freed_ids_q.size() > 0) begin
          g.id = freed_ids_q[0];
          freed_ids_q.delete(0);
        end else begin
          ok = bump_hw();
          while (ok && rsv_map[hw_cnt]) ok = bump_hw();
          if (ok) begin
            g.id = hw_cnt;
          end else begin
            g.st = ST_EXHAUSTED;
          end
        end
        if (g.st == ST_OK) begin
          granted_ids_q.insert(granted_ids_q.size(), g.id);
          if (granted_ids_q.size() > 64) granted_ids_q.delete(0);
        end
      end
      MODE_FREE: begin
        if (!unique_sh) begin
          if (id == hw_cnt) begin
            hw_cnt = hw_cnt - 1'b1;
          end else if (freed_ids_q.size() >= FREE_DEPTH) begin
            g.st = ST_OVERFLOW;
          end else begin
            freed_ids_q.insert(freed_ids_q.size(), id);
          end
        end
      end
      MODE_RESERVE: begin
        rsv_map[id] = 1'b1;
      end
      default: ;
    endcase
    expected_grant_q.insert(expected_grant_q.size(), g);
  endfunction

  function automatic flow_req_t make_request();
    flow_req_t r;
    int        pick;
    int        idx;
    r.hold = ($urandom_range(0, 99) == 0);
    r.id   = ID_BITS'($urandom);
    pick   = $urandom_range(0, 99);
    if (pick < 4) begin
      r.mode = MODE_UNUSED;
    end else if (pick < 46) begin
      r.mode = MODE_ALLOC;
    end else if (pick < 78) begin
      r.mode = MODE_FREE;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        r.id = hw_cnt;
      end else if (pick < 7 && granted_ids_q.size() > 0) begin
        idx  = $urandom_range(0, granted_ids_q.size() - 1);
        r.id = granted_ids_q[idx];
        granted_ids_q.delete(idx);
      end
    end else begin
      r.mode = MODE_RESERVE;
      if ($urandom_range(0, 9) < 6) begin
        r.id = hw_cnt + ID_BITS'($urandom_range(1, 3));
      end else begin
        r.id = ID_BITS'($urandom_range(0, 4000));
      end
    end
    return r;
  endfunction

  task automatic push_req(logic [MODE_BITS-1:0] m, logic [ID_BITS-1:0] id, bit hold = 1'b0);
    flow_req_t r;
    r.mode = m;
    r.id   = id;
    r.hold = hold;
    pending_req_q.insert(pending_req_q.size(), r);
  endtask

  task automatic wait_quiet();
    do @(negedge clk_i);
    while (pending_req_q.size() != 0 || expected_grant_q.size() != 0 || start !== 1'b0
           || busy !== 1'b0 || done_o !== 1'b0);
  endtask

  task automatic write_unique(bit v);
    wait_quiet();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * REG_UNIQUE_MODE);
    pwdata  <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    unique_sh = v;
  endtask

  task automatic run_random(int n, int gap);
    wait_quiet();
    gap_pct = gap;
    repeat (n) begin
      do @(negedge clk_i);
      while (pending_req_q.size() != 0);
      pending_req_q.insert(pending_req_q.size(), make_request());
    end
  endtask

  task automatic drain_free_list(int gap);
    wait_quiet();
    gap_pct = gap;
    repeat (freed_ids_q.size()) push_req(MODE_ALLOC, ID_BITS'($urandom));
  endtask

  always @(posedge clk_i) begin : drive_b
    flow_req_t nxt;
    bit        fire;
    fire = rst_ni && start && !busy;
    if (fire) compute_grant(mode_i, id_in_i);
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!(start && !fire)) begin
      if (pending_req_q.size() > 0 && $urandom_range(0, 99) >= gap_pct
          && !(pending_req_q[0].hold && (expected_grant_q.size() != 0 || done_o))) begin
        nxt = pending_req_q[0];
        pending_req_q.delete(0);
        start   <= 1'b1;
        mode_i  <= nxt.mode;
        id_in_i <= nxt.id;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_b
    grant_t want;
    if (rst_ni && done_o) begin
      if (expected_grant_q.size() == 0) begin
        $display("%0t: unexpected result id_out %0d status %0d", $time, id_out_o, status_o);
        err_cnt++;
      end else begin
        want = expected_grant_q[0];
        expected_grant_q.delete(0);
        if (id_out_o !== want.id) begin
          $display("%0t: id_out expected %0d actual %0d", $time, want.id, id_out_o);
          err_cnt++;
        end
        if (status_o !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status_o);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (psel && penable)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_unique(1'b0);
    gap_pct = 0;
    push_req(MODE_ALLOC, 12'd0);
    push_req(MODE_RESERVE, 12'd3);
    push_req(MODE_RESERVE, 12'd4);
    push_req(MODE_RESERVE, 12'd4);
    push_req(MODE_ALLOC, 12'd4095);
    push_req(MODE_FREE, 12'd5);
    push_req(MODE_ALLOC, 12'd0);
    push_req(MODE_FREE, 12'd2);
    push_req(MODE_FREE, 12'd4095);
    push_req(MODE_RESERVE, 12'd4095);
    push_req(MODE_ALLOC, 12'd0, 1'b1);
    push_req(MODE_ALLOC, 12'd0);
    push_req(MODE_UNUSED, 12'd4095);
    push_req(MODE_UNUSED, 12'd0);
    push_req(MODE_ALLOC, 12'd0);

    write_unique(1'b1);
    push_req(MODE_FREE, 12'd6);
    push_req(MODE_FREE, 12'd4095);
    run_random(240, 61);

    write_unique(1'b0);
    run_random(240, 0);
    run_random(240, 12);
    run_random(240, 61);

    // walk the counter down through zero so it wraps, then probe the limit
    drain_free_list(12);
    wait_quiet();
    gap_pct = 30;
    for (int v = int'(hw_cnt); v >= 0; v--) push_req(MODE_FREE, ID_BITS'(v));
    push_req(MODE_ALLOC, 12'd0);
    push_req(MODE_FREE, 12'd4095);
    push_req(MODE_FREE, 12'd4094);
    push_req(MODE_ALLOC, 12'd0);
    push_req(MODE_FREE, 12'd4093);
    push_req(MODE_ALLOC, 12'd0);
    push_req(MODE_FREE, 12'd4093);
    push_req(MODE_RESERVE, 12'd4093);
    push_req(MODE_ALLOC, 12'd0);
    push_req(MODE_ALLOC, 12'd0);

    wait_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && expected_grant_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
